/* hdl/cdq_pkg.sv */
// Shared types and constants for the circular deque.
// Holds the operation codes and the fixed field widths; no dependencies.
package cdq_pkg;

  localparam int unsigned KIND_W = 3;
  localparam int unsigned CFG_W  = 8;
  localparam int unsigned OCC_W  = 8;

  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [CFG_W-1:0]  cap_t;
  typedef logic [OCC_W-1:0]  occ_t;

  localparam kind_t KIND_PUSH_FRONT = 3'd0;
  localparam kind_t KIND_PUSH_BACK  = 3'd1;
  localparam kind_t KIND_POP_FRONT  = 3'd2;
  localparam kind_t KIND_POP_BACK   = 3'd3;
  localparam kind_t KIND_NOP        = 3'd4;

  localparam cap_t CAP_RESET = 8'd128;

endpackage

/* hdl/cdq_cell.sv */
// One ring slot of the circular deque plus one stage of the read probe chain.
// Does not use cdq_pkg; instantiated in a row by circular_deque.
module cdq_cell #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned IDX_W      = 7,
  parameter int unsigned SLOT       = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [IDX_W-1:0]      wr_idx,
  input  logic [DATA_WIDTH-1:0] wr_data,
  input  logic                  probe_vld_i,
  input  logic [IDX_W-1:0]      probe_head_i,
  input  logic [IDX_W-1:0]      probe_tail_i,
  input  logic [DATA_WIDTH-1:0] probe_front_i,
  input  logic [DATA_WIDTH-1:0] probe_rear_i,
  output logic                  probe_vld_o,
  output logic [IDX_W-1:0]      probe_head_o,
  output logic [IDX_W-1:0]      probe_tail_o,
  output logic [DATA_WIDTH-1:0] probe_front_o,
  output logic [DATA_WIDTH-1:0] probe_rear_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(SLOT);

  logic [DATA_WIDTH-1:0] slot_r;
  logic                  vld_r;
  logic [IDX_W-1:0]      head_r;
  logic [IDX_W-1:0]      tail_r;
  logic [DATA_WIDTH-1:0] front_r;
  logic [DATA_WIDTH-1:0] rear_r;

  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == MY_IDX)) begin
      slot_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= probe_vld_i;
    end
  end

  always_ff @(posedge clk) begin
    head_r  <= probe_head_i;
    tail_r  <= probe_tail_i;
    front_r <= (probe_head_i == MY_IDX) ? slot_r : probe_front_i;
    rear_r  <= (probe_tail_i == MY_IDX) ? slot_r : probe_rear_i;
  end

  assign probe_vld_o   = vld_r;
  assign probe_head_o  = head_r;
  assign probe_tail_o  = tail_r;
  assign probe_front_o = front_r;
  assign probe_rear_o  = rear_r;

endmodule

/* hdl/cdq_ctrl.sv */
// Control unit of the circular deque: capacity register, head, tail and count,
// slot writes, probe launch and the result register. Depends on cdq_pkg.
module cdq_ctrl #(
  parameter int unsigned DEPTH      = 128,
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned IDX_W      = 7
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  cdq_pkg::cap_t                cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  cdq_pkg::kind_t               in_kind,
  input  logic signed [DATA_WIDTH-1:0] in_push_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_accepted,
  output logic signed [DATA_WIDTH-1:0] out_front_value,
  output logic signed [DATA_WIDTH-1:0] out_rear_value,
  output logic                         out_is_full,
  output logic                         out_is_empty,
  output cdq_pkg::occ_t                out_occupancy,
  output logic                         wr_en,
  output logic [IDX_W-1:0]             wr_idx,
  output logic [DATA_WIDTH-1:0]        wr_data,
  output logic                         launch_vld,
  output logic [IDX_W-1:0]             launch_head,
  output logic [IDX_W-1:0]             launch_tail,
  input  logic                         ret_vld,
  input  logic [DATA_WIDTH-1:0]        ret_front,
  input  logic [DATA_WIDTH-1:0]        ret_rear
);

  localparam int unsigned CMP_W = ((IDX_W > cdq_pkg::CFG_W) ? IDX_W : cdq_pkg::CFG_W) + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] i,
                                               input cdq_pkg::cap_t cap);
    logic [CMP_W-1:0] n;
    n = CMP_W'(i) + CMP_W'(1);
    return (n >= CMP_W'(cap)) ? '0 : IDX_W'(n);
  endfunction

  function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] i,
                                                 input cdq_pkg::cap_t cap);
    logic [CMP_W-1:0] c1;
    c1 = CMP_W'(cap) - CMP_W'(1);
    return ((i == '0) || (CMP_W'(i) > CMP_W'(cap))) ? IDX_W'(c1) : i - IDX_W'(1);
  endfunction

  logic [1:0]            state_r, state_nxt;
  cdq_pkg::cap_t         cap_cfg_r;
  logic [IDX_W-1:0]      head_r, head_nxt;
  logic [IDX_W-1:0]      tail_r, tail_nxt;
  cdq_pkg::occ_t         count_r, count_nxt;
  logic                  launch_r;
  logic                  ok_r, ok_nxt;
  logic                  full_r;
  logic                  empty_r;
  logic                  res_ok_r;
  logic [DATA_WIDTH-1:0] res_front_r;
  logic [DATA_WIDTH-1:0] res_rear_r;
  logic                  res_full_r;
  logic                  res_empty_r;
  cdq_pkg::occ_t         res_occ_r;
  cdq_pkg::cap_t         cap;
  logic                  is_full;
  logic                  is_empty;
  logic                  take;
  logic                  wr_en_c;
  logic [IDX_W-1:0]      wr_idx_c;

  always_comb begin
    if (cap_cfg_r == '0) begin
      cap = cdq_pkg::cap_t'(1);
    end else if (CMP_W'(cap_cfg_r) > CMP_W'(DEPTH)) begin
      cap = cdq_pkg::cap_t'(DEPTH);
    end else begin
      cap = cap_cfg_r;
    end
  end

  assign is_full  = (count_r >= cap);
  assign is_empty = (count_r == '0);
  assign in_ready = rst_n && (state_r == ST_IDLE);
  assign take     = in_valid && in_ready;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    ok_nxt    = 1'b1;
    wr_en_c   = 1'b0;
    wr_idx_c  = '0;
    case (in_kind)
      cdq_pkg::KIND_PUSH_FRONT, cdq_pkg::KIND_PUSH_BACK: begin
        if (is_full) begin
          ok_nxt = 1'b0;
        end else begin
          wr_en_c = 1'b1;
          if (is_empty) begin
            head_nxt = '0;
            tail_nxt = '0;
            wr_idx_c = '0;
          end else if (in_kind == cdq_pkg::KIND_PUSH_FRONT) begin
            head_nxt = step_down(head_r, cap);
            wr_idx_c = head_nxt;
          end else begin
            tail_nxt = step_up(tail_r, cap);
            wr_idx_c = tail_nxt;
          end
          count_nxt = count_r + cdq_pkg::occ_t'(1);
        end
      end
      cdq_pkg::KIND_POP_FRONT, cdq_pkg::KIND_POP_BACK: begin
        if (is_empty) begin
          ok_nxt = 1'b0;
        end else begin
          if (count_r == cdq_pkg::occ_t'(1)) begin
            head_nxt = '0;
            tail_nxt = '0;
          end else if (in_kind == cdq_pkg::KIND_POP_FRONT) begin
            head_nxt = step_up(head_r, cap);
          end else begin
            tail_nxt = step_down(tail_r, cap);
          end
          count_nxt = count_r - cdq_pkg::occ_t'(1);
        end
      end
      default: begin
        ok_nxt = 1'b1;
      end
    endcase
  end

  assign wr_en   = take && wr_en_c;
  assign wr_idx  = wr_idx_c;
  assign wr_data = in_push_value;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (ret_vld) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cap_cfg_r <= cdq_pkg::CAP_RESET;
      head_r    <= '0;
      tail_r    <= '0;
      count_r   <= '0;
      launch_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      launch_r <= take;
      if (cfg_wr_en) begin
        cap_cfg_r <= cfg_wr_data;
      end
      if (take) begin
        head_r  <= head_nxt;
        tail_r  <= tail_nxt;
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ok_r    <= ok_nxt;
      full_r  <= (count_nxt >= cap);
      empty_r <= (count_nxt == '0);
    end
    if ((state_r == ST_RUN) && ret_vld) begin
      res_ok_r    <= ok_r;
      res_front_r <= empty_r ? '1 : ret_front;
      res_rear_r  <= empty_r ? '1 : ret_rear;
      res_full_r  <= full_r;
      res_empty_r <= empty_r;
      res_occ_r   <= count_r;
    end
  end

  assign launch_vld  = launch_r;
  assign launch_head = head_r;
  assign launch_tail = tail_r;

  assign out_valid       = (state_r == ST_DONE);
  assign out_accepted    = res_ok_r;
  assign out_front_value = res_front_r;
  assign out_rear_value  = res_rear_r;
  assign out_is_full     = res_full_r;
  assign out_is_empty    = res_empty_r;
  assign out_occupancy   = res_occ_r;

  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  a_launch: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> (launch_r && (state_r == ST_RUN)))
    else $error("probe not launched after a transaction");

  a_ret_run: assert property (@(posedge clk) disable iff (!rst_n)
    ret_vld |-> (state_r == ST_RUN))
    else $error("probe returned outside a run");

  a_empty_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> ((head_r == '0) && (tail_r == '0)))
    else $error("indices not cleared while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(count_r) <= CMP_W'(DEPTH))
    else $error("element count beyond depth");

endmodule

/* hdl/circular_deque.sv */
// Circular deque: a double-ended queue in a ring of DEPTH slots.
// Channels: the input transaction carries in_kind (push front, push back,
// pop front, pop back, no change) and in_push_value; the result transaction
// reports out_accepted, the front and rear values after the operation (all
// ones when empty), out_is_full, out_is_empty and out_occupancy.
// cfg_wr_en with cfg_wr_data sets the number of ring slots in use; write it
// only while no transaction is in flight.
// The slots form a row of DEPTH cells. An operation updates head, tail and
// count and writes its slot on the accepting edge; a read probe then walks
// the row one cell per cycle and picks up the front and rear values.
// The result is registered when the probe returns from the last cell. Only one
// transaction is handled at a time: a new one is accepted only after the
// result is taken, so the walk through the cell row sets the throughput.
// Reset (rst_n, synchronous, active low) empties the deque and sets the
// capacity to 128 slots. Slot contents are not cleared and need no pass.
// When the receiver stalls, the result is held and no new transaction is
// accepted until it is taken.
// Depends on cdq_pkg, cdq_ctrl and cdq_cell.
module circular_deque #(
  parameter int unsigned DEPTH      = 128,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  cdq_pkg::cap_t                cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  cdq_pkg::kind_t               in_kind,
  input  logic signed [DATA_WIDTH-1:0] in_push_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_accepted,
  output logic signed [DATA_WIDTH-1:0] out_front_value,
  output logic signed [DATA_WIDTH-1:0] out_rear_value,
  output logic                         out_is_full,
  output logic                         out_is_empty,
  output cdq_pkg::occ_t                out_occupancy
);

  localparam int unsigned IDX_W = $clog2(DEPTH);

  logic                  wr_en;
  logic [IDX_W-1:0]      wr_idx;
  logic [DATA_WIDTH-1:0] wr_data;

  logic [DEPTH:0]        p_vld;
  logic [IDX_W-1:0]      p_head  [DEPTH+1];
  logic [IDX_W-1:0]      p_tail  [DEPTH+1];
  logic [DATA_WIDTH-1:0] p_front [DEPTH+1];
  logic [DATA_WIDTH-1:0] p_rear  [DEPTH+1];

  cdq_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_push_value   (in_push_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_accepted    (out_accepted),
    .out_front_value (out_front_value),
    .out_rear_value  (out_rear_value),
    .out_is_full     (out_is_full),
    .out_is_empty    (out_is_empty),
    .out_occupancy   (out_occupancy),
    .wr_en           (wr_en),
    .wr_idx          (wr_idx),
    .wr_data         (wr_data),
    .launch_vld      (p_vld[0]),
    .launch_head     (p_head[0]),
    .launch_tail     (p_tail[0]),
    .ret_vld         (p_vld[DEPTH]),
    .ret_front       (p_front[DEPTH]),
    .ret_rear        (p_rear[DEPTH])
  );

  assign p_front[0] = '0;
  assign p_rear[0]  = '0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    cdq_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX_W      (IDX_W),
      .SLOT       (g)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .wr_en         (wr_en),
      .wr_idx        (wr_idx),
      .wr_data       (wr_data),
      .probe_vld_i   (p_vld[g]),
      .probe_head_i  (p_head[g]),
      .probe_tail_i  (p_tail[g]),
      .probe_front_i (p_front[g]),
      .probe_rear_i  (p_rear[g]),
      .probe_vld_o   (p_vld[g+1]),
      .probe_head_o  (p_head[g+1]),
      .probe_tail_o  (p_tail[g+1]),
      .probe_front_o (p_front[g+1]),
      .probe_rear_o  (p_rear[g+1])
    );
  end

endmodule

/* tb/cdq_checker.sv */
`timescale 1ns / 100ps
// Checker for the circular deque: follows the configuration port and both channels,
// predicts every result transaction and compares it field by field.
// Depends on cdq_pkg.
module cdq_checker #(
  parameter int unsigned DEPTH      = 128,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  cdq_pkg::cap_t         cfg_wr_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  cdq_pkg::kind_t        in_kind,
  input  logic [DATA_WIDTH-1:0] in_push_value,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  out_accepted,
  input  logic [DATA_WIDTH-1:0] out_front_value,
  input  logic [DATA_WIDTH-1:0] out_rear_value,
  input  logic                  out_is_full,
  input  logic                  out_is_empty,
  input  cdq_pkg::occ_t         out_occupancy,
  output int unsigned           fail_count,
  output int unsigned           pending_count
);

  typedef struct packed {
    logic                  accepted;
    logic [DATA_WIDTH-1:0] front;
    logic [DATA_WIDTH-1:0] rear;
    logic                  full;
    logic                  empty;
    cdq_pkg::occ_t         occupancy;
  } deque_status_t;

  logic [DATA_WIDTH-1:0] slot_mem [DEPTH];
  int unsigned           head_pos;
  int unsigned           tail_pos;
  int unsigned           held;
  int unsigned           cap_setting;
  deque_status_t         status_q [$];

  function automatic int unsigned usable_slots();
    int unsigned c;
    c = cap_setting;
    if (c == 0) c = 1;
    if (c > DEPTH) c = DEPTH;
    return c;
  endfunction

  function automatic int unsigned wrap_up(int unsigned idx, int unsigned cap);
    return (idx + 1 >= cap) ? 0 : idx + 1;
  endfunction

  function automatic int unsigned wrap_down(int unsigned idx, int unsigned cap);
    return (idx == 0 || idx > cap) ? cap - 1 : idx - 1;
  endfunction

  function automatic deque_status_t apply_operation(cdq_pkg::kind_t kind,
                                                    logic [DATA_WIDTH-1:0] value);
    int unsigned   cap;
    deque_status_t res;
    cap = usable_slots();
    res.accepted = 1'b1;
    case (kind)
      cdq_pkg::KIND_PUSH_FRONT, cdq_pkg::KIND_PUSH_BACK: begin
        if (held >= cap) begin
          res.accepted = 1'b0;
        end else begin
          if (held == 0) begin
            head_pos = 0;
            tail_pos = 0;
          end else if (kind == cdq_pkg::KIND_PUSH_FRONT) begin
            head_pos = wrap_down(head_pos, cap);
          end else begin
            tail_pos = wrap_up(tail_pos, cap);
          end
          slot_mem[(kind == cdq_pkg::KIND_PUSH_FRONT) ? head_pos : tail_pos] = value;
          held++;
        end
      end
      cdq_pkg::KIND_POP_FRONT, cdq_pkg::KIND_POP_BACK: begin
        if (held == 0) begin
          res.accepted = 1'b0;
        end else begin
          if (held == 1) begin
            head_pos = 0;
            tail_pos = 0;
          end else if (kind == cdq_pkg::KIND_POP_FRONT) begin
            head_pos = wrap_up(head_pos, cap);
          end else begin
            tail_pos = wrap_down(tail_pos, cap);
          end
          held--;
        end
      end
      default: ;
    endcase
    res.empty     = (held == 0);
    res.full      = (held >= cap);
    res.front     = res.empty ? '1 : slot_mem[head_pos % DEPTH];
    res.rear      = res.empty ? '1 : slot_mem[tail_pos % DEPTH];
    res.occupancy = cdq_pkg::occ_t'(held);
    return res;
  endfunction

  task automatic check_field(string name, logic [DATA_WIDTH-1:0] want,
                             logic [DATA_WIDTH-1:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    deque_status_t want;
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) slot_mem[i] = '0;
      head_pos    = 0;
      tail_pos    = 0;
      held        = 0;
      cap_setting = 32'(cdq_pkg::CAP_RESET);
      fail_count  = 0;
      status_q.delete();
    end else begin
      if (cfg_wr_en) cap_setting = 32'(cfg_wr_data);
      if (out_valid && out_ready) begin
        if (status_q.size() == 0) begin
          fail_count++;
          $display("%0t: result transaction expected none, actual occupancy %0d",
                   $time, out_occupancy);
        end else begin
          want = status_q.pop_front();
          check_field("accepted", DATA_WIDTH'(want.accepted), DATA_WIDTH'(out_accepted));
          check_field("front_value", want.front, out_front_value);
          check_field("rear_value", want.rear, out_rear_value);
          check_field("is_full", DATA_WIDTH'(want.full), DATA_WIDTH'(out_is_full));
          check_field("is_empty", DATA_WIDTH'(want.empty), DATA_WIDTH'(out_is_empty));
          check_field("occupancy", DATA_WIDTH'(want.occupancy),
                      DATA_WIDTH'(out_occupancy));
        end
      end
      if (in_valid && in_ready) status_q.push_back(apply_operation(in_kind, in_push_value));
    end
    pending_count = status_q.size();
  end

endmodule

/* tb/circular_deque_tb.sv */
`timescale 1ns / 100ps
// Testbench top for circular_deque: reset, capacity writes and operation streams
// under changing flow control, then the verdict. Depends on cdq_pkg, cdq_checker
// and the circular_deque RTL.
module circular_deque_tb;

  localparam int unsigned DEPTH      = 128;
  localparam int unsigned DATA_WIDTH = 32;

  localparam cdq_pkg::kind_t KIND_RSVD5 = 3'd5;
  localparam cdq_pkg::kind_t KIND_RSVD6 = 3'd6;
  localparam cdq_pkg::kind_t KIND_RSVD7 = 3'd7;

  logic                         clk           = 1'b0;
  logic                         rst_n         = 1'b0;
  logic                         cfg_wr_en     = 1'b0;
  cdq_pkg::cap_t                cfg_wr_data   = cdq_pkg::CAP_RESET;
  logic                         in_valid      = 1'b0;
  logic                         in_ready;
  cdq_pkg::kind_t               in_kind       = cdq_pkg::KIND_NOP;
  logic signed [DATA_WIDTH-1:0] in_push_value = '0;
  logic                         out_valid;
  logic                         out_ready     = 1'b0;
  logic                         out_accepted;
  logic signed [DATA_WIDTH-1:0] out_front_value;
  logic signed [DATA_WIDTH-1:0] out_rear_value;
  logic                         out_is_full;
  logic                         out_is_empty;
  cdq_pkg::occ_t                out_occupancy;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned sent_count     = 0;
  int unsigned results_seen   = 0;
  logic        last_empty     = 1'b1;

  cdq_pkg::kind_t no_change_kinds [4] =
    '{cdq_pkg::KIND_NOP, KIND_RSVD5, KIND_RSVD6, KIND_RSVD7};

  circular_deque #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_push_value   (in_push_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_accepted    (out_accepted),
    .out_front_value (out_front_value),
    .out_rear_value  (out_rear_value),
    .out_is_full     (out_is_full),
    .out_is_empty    (out_is_empty),
    .out_occupancy   (out_occupancy)
  );

  cdq_checker #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_push_value   (in_push_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_accepted    (out_accepted),
    .out_front_value (out_front_value),
    .out_rear_value  (out_rear_value),
    .out_is_full     (out_is_full),
    .out_is_empty    (out_is_empty),
    .out_occupancy   (out_occupancy),
    .fail_count      (fail_count),
    .pending_count   (pending_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      last_empty   <= out_is_empty;
    end
  end

  function automatic logic [DATA_WIDTH-1:0] random_value();
    case ($urandom_range(7))
      0: return {1'b0, {(DATA_WIDTH-1){1'b1}}};
      1: return {1'b1, {(DATA_WIDTH-1){1'b0}}};
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_op(cdq_pkg::kind_t kind, logic [DATA_WIDTH-1:0] value);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_push_value <= value;
    do @(posedge clk); while (!in_ready);
    sent_count++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_seen != sent_count);
  endtask

  task automatic write_cap(cdq_pkg::cap_t value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    int unsigned tries;
    tries = 0;
    settle();
    while (!last_empty && tries < DEPTH + 2) begin
      send_op($urandom_range(1) ? cdq_pkg::KIND_POP_BACK : cdq_pkg::KIND_POP_FRONT,
              random_value());
      settle();
      tries++;
    end
  endtask

  task automatic random_ops(int unsigned n, int unsigned push_pct, int unsigned pop_pct);
    int unsigned    roll;
    cdq_pkg::kind_t kind;
    repeat (n) begin
      roll = $urandom_range(99);
      if (roll < push_pct) begin
        kind = $urandom_range(1) ? cdq_pkg::KIND_PUSH_BACK : cdq_pkg::KIND_PUSH_FRONT;
      end else if (roll < push_pct + pop_pct) begin
        kind = $urandom_range(1) ? cdq_pkg::KIND_POP_BACK : cdq_pkg::KIND_POP_FRONT;
      end else begin
        kind = no_change_kinds[2'($urandom_range(3))];
      end
      send_op(kind, random_value());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty deque refusals, field extremes, unused kinds and pops down to empty.
    write_cap(cdq_pkg::CAP_RESET);
    send_op(cdq_pkg::KIND_NOP, random_value());
    send_op(cdq_pkg::KIND_POP_FRONT, random_value());
    send_op(cdq_pkg::KIND_POP_BACK, random_value());
    send_op(cdq_pkg::KIND_PUSH_BACK, 32'h7fff_ffff);
    send_op(cdq_pkg::KIND_PUSH_FRONT, 32'h8000_0000);
    send_op(cdq_pkg::KIND_PUSH_BACK, 32'h0000_0000);
    send_op(cdq_pkg::KIND_PUSH_FRONT, 32'hffff_ffff);
    send_op(KIND_RSVD5, random_value());
    send_op(KIND_RSVD6, random_value());
    send_op(KIND_RSVD7, random_value());
    send_op(cdq_pkg::KIND_POP_BACK, random_value());
    send_op(cdq_pkg::KIND_POP_FRONT, random_value());
    send_op(cdq_pkg::KIND_POP_BACK, random_value());
    send_op(cdq_pkg::KIND_POP_FRONT, random_value());
    send_op(cdq_pkg::KIND_PUSH_FRONT, 32'h5555_5555);
    send_op(cdq_pkg::KIND_PUSH_BACK, 32'haaaa_aaaa);
    send_op(cdq_pkg::KIND_POP_FRONT, random_value());
    send_op(cdq_pkg::KIND_POP_BACK, random_value());
    send_op(cdq_pkg::KIND_NOP, random_value());
    drain();

    send_idle_pct = 55;
    write_cap(8'd1);
    random_ops(40, 45, 40);
    drain();

    send_idle_pct  = 0;
    recv_stall_pct = 55;
    write_cap(8'd0);
    random_ops(20, 45, 40);
    drain();

    send_idle_pct = 9;
    recv_stall_pct = 9;
    write_cap(8'd3);
    random_ops(50, 50, 35);
    drain();

    // Capacity dropped below the number of elements held.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_cap(cdq_pkg::CAP_RESET);
    repeat (12) send_op(cdq_pkg::KIND_PUSH_BACK, random_value());
    settle();
    recv_stall_pct = 55;
    write_cap(8'd5);
    random_ops(40, 40, 40);
    drain();

    send_idle_pct  = 55;
    recv_stall_pct = 0;
    write_cap(8'd255);
    random_ops(140, 97, 2);
    send_idle_pct = 0;
    random_ops(80, 10, 85);
    drain();

    send_idle_pct  = 9;
    recv_stall_pct = 9;
    write_cap(8'd64);
    random_ops(50, 50, 45);
    drain();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_cap(8'd2);
    random_ops(20, 50, 40);
    settle();

    repeat (DEPTH + 8) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("circular_deque verification clean");
    end else begin
      $display("circular_deque verification failed");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("circular_deque verification failed");
    $finish;
  end

endmodule

/* files.f */
hdl/cdq_pkg.sv
hdl/cdq_cell.sv
hdl/cdq_ctrl.sv
hdl/circular_deque.sv
tb/cdq_checker.sv
tb/circular_deque_tb.sv
